// File: src/iss_pkg.sv
package iss_pkg;

    // Operation codes carried in the op field
    typedef enum logic [2:0] {
        OP_ADD_HEAD  = 3'd0,
        OP_ADD_TAIL  = 3'd1,
        OP_INSERT    = 3'd2,
        OP_DEL_FIRST = 3'd3,
        OP_DEL_LAST  = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_WRITE     = 3'd6,
        OP_READ      = 3'd7
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // What every cell of the row does on an accepted item
    typedef enum logic [1:0] {
        CK_HOLD   = 2'd0,
        CK_INSERT = 2'd1,
        CK_REMOVE = 2'd2,
        CK_WRITE  = 2'd3
    } t_cell_op;

    // Field widths of the stream items
    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int RDATA_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // Broadcast command from the decoder to the row of cells
    typedef struct packed {
        t_cell_op op;
        logic     rd_en;
    } t_row_cmd;

endpackage

// File: src/indexed_sequence_store_top.sv
// Channel   Dir  Item fields (tdata, lowest bit up)
// -------   ---  -------------------------------------------------
// s_axis    in   op[2:0], position[7:3], value[39:8]
// m_axis    out  read_data[31:0], status[33:32], occupancy[38:34]
//
// One item per clock while m_axis is not stalled: the row of word cells shifts, loads or holds in the
// same cycle the item is taken, and the result lands in the output register.
// The result is on m_axis in the cycle after acceptance.
// Reset clears the word count and the output valid flag; stored words are
// not cleared, as no word is visible until written.
// o_s_tready is high while the output register is empty or being drained.
module indexed_sequence_store_top #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // op[2:0], position[7:3], value[39:8]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // read_data[31:0], status[33:32], occupancy[38:34]
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int RN   = (CAPACITY < 32) ? CAPACITY : 32;
    localparam int RIW  = $clog2(RN);
    localparam int OCMW = (CW > iss_pkg::OCC_W) ? CW : iss_pkg::OCC_W;

    // Input unpacking
    iss_pkg::t_op                    in_op;
    logic [iss_pkg::POS_W-1:0]       in_pos;
    logic [iss_pkg::VALUE_W-1:0]     in_value;
    logic [63:0]                     value_x;
    logic [DATA_WIDTH-1:0]           in_word;

    assign in_op    = iss_pkg::t_op'(i_s_tdata[2:0]);
    assign in_pos   = i_s_tdata[7:3];
    assign in_value = i_s_tdata[39:8];
    assign value_x  = 64'(in_value);
    assign in_word  = value_x[DATA_WIDTH-1:0];

    logic accept;
    assign o_s_tready = !o_m_tvalid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    // Word count
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    // Decode
    iss_pkg::t_status  dec_status;
    iss_pkg::t_row_cmd dec_cmd;
    logic [CW-1:0]     dec_at;
    logic [CW-1:0]     dec_count;

    iss_decode #(
        .CAPACITY(CAPACITY)
    ) u_decode (
        .i_op        (in_op),
        .i_position  (in_pos),
        .i_count     (r_count),
        .o_status    (dec_status),
        .o_cmd       (dec_cmd),
        .o_at        (dec_at),
        .o_next_count(dec_count)
    );

    // Row of cells, commanded only on an accepted item
    iss_pkg::t_cell_op      cell_op;
    logic [DATA_WIDTH-1:0]  cell_word [CAPACITY];

    assign cell_op = accept ? dec_cmd.op : iss_pkg::CK_HOLD;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_w;
        logic [DATA_WIDTH-1:0] right_w;
        if (g == 0) begin : g_first
            assign left_w = in_word;
        end else begin : g_mid_l
            assign left_w = cell_word[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_w = cell_word[g];
        end else begin : g_mid_r
            assign right_w = cell_word[g+1];
        end
        iss_cell #(
            .AW (CW),
            .DW (DATA_WIDTH),
            .IDX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_op   (cell_op),
            .i_at   (dec_at),
            .i_word (in_word),
            .i_left (left_w),
            .i_right(right_w),
            .o_word (cell_word[g])
        );
    end

    // Read select: a position is at most 31, so only the first cells are reachable
    logic [DATA_WIDTH-1:0]       rd_word;
    logic [63:0]                 rd_x;
    logic [iss_pkg::RDATA_W-1:0] n_rdata;

    assign rd_word = cell_word[in_pos[RIW-1:0]];
    assign rd_x    = 64'(rd_word);
    assign n_rdata = dec_cmd.rd_en ? rd_x[iss_pkg::RDATA_W-1:0] : '0;

    assign n_count = accept ? dec_count : r_count;

    // Occupancy masked to its field width
    logic [OCMW-1:0]           occ_x;
    logic [iss_pkg::OCC_W-1:0] n_occ;
    assign occ_x = OCMW'(dec_count);
    assign n_occ = occ_x[iss_pkg::OCC_W-1:0];

    // Count and output register
    logic [iss_pkg::RDATA_W-1:0] r_rdata;
    iss_pkg::t_status            r_status;
    logic [iss_pkg::OCC_W-1:0]   r_occ;
    logic                        r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rdata  <= n_rdata;
            r_status <= dec_status;
            r_occ    <= n_occ;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_occ, r_status, r_rdata};

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("word count above capacity");

    a_err_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && dec_status != iss_pkg::ST_OK |=> r_count == $past(r_count))
        else $error("failed item changed the word count");

    a_err_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && r_status != iss_pkg::ST_OK |-> r_rdata == '0)
        else $error("read data set on a failed item");

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_count))
        else $error("word count moved without an item");

endmodule

// File: src/iss_cell.sv
module iss_cell #(
    parameter int AW  = 5,
    parameter int DW  = 32,
    parameter int IDX = 0
) (
    input  logic                 i_clk,
    input  iss_pkg::t_cell_op    i_op,
    input  logic [AW-1:0]        i_at,
    input  logic [DW-1:0]        i_word,
    input  logic [DW-1:0]        i_left,
    input  logic [DW-1:0]        i_right,
    output logic [DW-1:0]        o_word
);

    localparam logic [AW-1:0] MY_IDX = AW'(IDX);

    logic [DW-1:0] r_word;
    logic [DW-1:0] n_word;

    // Shift from a neighbour, load the new word, or hold
    always_comb begin
        n_word = r_word;
        case (i_op)
            iss_pkg::CK_INSERT: begin
                if (MY_IDX > i_at) begin
                    n_word = i_left;
                end else if (MY_IDX == i_at) begin
                    n_word = i_word;
                end
            end
            iss_pkg::CK_REMOVE: begin
                if (MY_IDX >= i_at) begin
                    n_word = i_right;
                end
            end
            iss_pkg::CK_WRITE: begin
                if (MY_IDX == i_at) begin
                    n_word = i_word;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    // Payload only, no reset
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

// File: src/iss_decode.sv
module iss_decode #(
    parameter int CAPACITY = 16
) (
    input  iss_pkg::t_op                    i_op,
    input  logic [iss_pkg::POS_W-1:0]       i_position,
    input  logic [$clog2(CAPACITY+1)-1:0]   i_count,
    output iss_pkg::t_status                o_status,
    output iss_pkg::t_row_cmd               o_cmd,
    output logic [$clog2(CAPACITY+1)-1:0]   o_at,
    output logic [$clog2(CAPACITY+1)-1:0]   o_next_count
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > iss_pkg::POS_W) ? CW : iss_pkg::POS_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE      = CW'(1);

    logic [CMPW-1:0] pos_x;
    logic [CMPW-1:0] cnt_x;
    logic            empty;
    logic            full;
    logic [CW-1:0]   pos_c;

    assign pos_x = CMPW'(i_position);
    assign cnt_x = CMPW'(i_count);
    assign empty = (i_count == '0);
    assign full  = (i_count == FULL_CNT);
    // Only used once the position is known to be within the count
    assign pos_c = pos_x[CW-1:0];

    // Status checks in the order: empty, position, full
    always_comb begin
        o_status     = iss_pkg::ST_OK;
        o_cmd.op     = iss_pkg::CK_HOLD;
        o_cmd.rd_en  = 1'b0;
        o_at         = '0;
        o_next_count = i_count;
        unique case (i_op) inside
            iss_pkg::OP_ADD_HEAD, iss_pkg::OP_ADD_TAIL: begin
                if (full) begin
                    o_status = iss_pkg::ST_FULL;
                end else begin
                    o_cmd.op     = iss_pkg::CK_INSERT;
                    o_at         = (i_op == iss_pkg::OP_ADD_HEAD) ? '0 : i_count;
                    o_next_count = i_count + ONE;
                end
            end
            iss_pkg::OP_INSERT: begin
                if (pos_x > cnt_x) begin
                    o_status = iss_pkg::ST_BADPOS;
                end else if (full) begin
                    o_status = iss_pkg::ST_FULL;
                end else begin
                    o_cmd.op     = iss_pkg::CK_INSERT;
                    o_at         = pos_c;
                    o_next_count = i_count + ONE;
                end
            end
            iss_pkg::OP_DEL_FIRST, iss_pkg::OP_DEL_LAST: begin
                if (empty) begin
                    o_status = iss_pkg::ST_EMPTY;
                end else begin
                    o_cmd.op     = iss_pkg::CK_REMOVE;
                    o_at         = (i_op == iss_pkg::OP_DEL_FIRST) ? '0 : i_count - ONE;
                    o_next_count = i_count - ONE;
                end
            end
            default: begin
                // delete at, write, read
                if (empty) begin
                    o_status = iss_pkg::ST_EMPTY;
                end else if (pos_x >= cnt_x) begin
                    o_status = iss_pkg::ST_BADPOS;
                end else begin
                    o_at = pos_c;
                    if (i_op == iss_pkg::OP_DEL_AT) begin
                        o_cmd.op     = iss_pkg::CK_REMOVE;
                        o_next_count = i_count - ONE;
                    end else if (i_op == iss_pkg::OP_WRITE) begin
                        o_cmd.op = iss_pkg::CK_WRITE;
                    end else begin
                        o_cmd.rd_en = 1'b1;
                    end
                end
            end
        endcase
    end

endmodule
